// ----- rtl/lcr_pkg.sv -----
// Shared types, byte codes and keyword tables for the line command recognizer.
`default_nettype none

package lcr_pkg;

   // Default line capacity; the store holds one character less than this.
   localparam int LINE_CAPACITY_DEFAULT = 20;

   // Line terminator bytes and the zero byte.
   localparam logic [7:0] BYTE_LF = 8'd10;
   localparam logic [7:0] BYTE_CR = 8'd13;
   localparam logic [7:0] BYTE_NUL = 8'd0;

   // Command codes.
   localparam logic [2:0] CMD_NONE = 3'd0;
   localparam logic [2:0] CMD_ARM = 3'd1;
   localparam logic [2:0] CMD_DISARM = 3'd2;
   localparam logic [2:0] CMD_HB_ACK = 3'd3;
   localparam logic [2:0] CMD_FORCE_ALARM = 3'd4;
   localparam logic [2:0] CMD_STOP_ALARM = 3'd5;
   localparam logic [2:0] CMD_QUERY = 3'd6;
   localparam logic [2:0] CMD_RESTART = 3'd7;

   // Keyword table. Text is right-justified in the packed vector.
   localparam int KW_NUM = 9;
   localparam int KW_MAX_LEN = 14;

   typedef logic [KW_MAX_LEN*8-1:0] kw_text_type;

   localparam kw_text_type KW_TEXT [KW_NUM] = '{
      "1", "0", "HB_ACK", {"ERZWINGE", "_ALARM"}, {"ALARM", "_STOP"},
      "SCHARF", "UNSCHARF", "STATUS", "REBOOT"
   };

   localparam int KW_LEN [KW_NUM] = '{1, 1, 6, 14, 10, 6, 8, 6, 6};

   localparam logic [2:0] KW_CODE [KW_NUM] = '{
      CMD_ARM, CMD_DISARM, CMD_HB_ACK, CMD_FORCE_ALARM, CMD_STOP_ALARM,
      CMD_ARM, CMD_DISARM, CMD_QUERY, CMD_RESTART
   };

   // One result item.
   typedef struct packed {
      logic [2:0] command;
      logic       line_complete;
   } rsp_type;

   // Character at position p (first character is position 0) of keyword k.
   function automatic logic [7:0] kw_char(input int k, input int p);
      kw_char = KW_TEXT[k][8*(KW_LEN[k]-1-p) +: 8];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/line_command_recognizer_unit.sv -----
// Top level of the line command recognizer: input register, line tracker, result register.
//
//   Channel  Ports                                   Dir  Meaning
//   req      req_valid, req_ready, req_rx_byte       in   one received byte
//   rsp      rsp_valid, rsp_ready, rsp_command,      out  command code per byte
//            rsp_line_complete
//
// One byte is accepted per cycle while the result is not stalled; each byte
// passes the input register, then the result register, to the rsp ports. The
// line state update and the parallel keyword compare sit between those two
// registers. Synchronous reset empties the line. A stalled result holds the
// pipeline, while the input register still takes a byte if it is empty.
`default_nettype none

module line_command_recognizer_unit #(
   parameter int LINE_CAPACITY = lcr_pkg::LINE_CAPACITY_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_command,
   output logic            rsp_line_complete
);

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             out_valid_ff;
   lcr_pkg::rsp_type out_ff;
   lcr_pkg::rsp_type result;
   logic             advance;

   // The staged byte moves on when the result register is free or being emptied.
   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   lcr_line_tracker #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_tracker (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .rx_byte(in_byte_ff),
      .result (result)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_command = out_ff.command;
   assign rsp_line_complete = out_ff.line_complete;

   // A command is only reported on a completed line.
   a_cmd_needs_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_line_complete) |-> (rsp_command == lcr_pkg::CMD_NONE))
      else $error("command reported without a completed line");

   // A full pipeline with a stalled result takes no new byte.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("byte accepted while pipeline is full and stalled");

endmodule

`default_nettype wire

// ----- rtl/lcr_keyword_match.sv -----
// Parallel keyword compare: per-position character hits and final command lookup.
`default_nettype none

module lcr_keyword_match #(
   parameter int FILL_W = 5
) (
   input  wire logic [7:0]                rx_byte,
   input  wire logic [FILL_W-1:0]         position,
   input  wire logic [FILL_W-1:0]         eff_len,
   input  wire logic [lcr_pkg::KW_NUM-1:0] prefix_ok,
   output logic      [lcr_pkg::KW_NUM-1:0] char_hit,
   output logic      [2:0]                command
);

   logic [lcr_pkg::KW_NUM-1:0][lcr_pkg::KW_MAX_LEN-1:0] pos_hit;

   // Each keyword checks the incoming byte against its character at this position.
   for (genvar k = 0; k < lcr_pkg::KW_NUM; k++) begin : g_kw
      for (genvar p = 0; p < lcr_pkg::KW_MAX_LEN; p++) begin : g_pos
         if (p < lcr_pkg::KW_LEN[k]) begin : g_used
            assign pos_hit[k][p] = (position == FILL_W'(p))
                                   && (rx_byte == lcr_pkg::kw_char(k, p));
         end else begin : g_unused
            assign pos_hit[k][p] = 1'b0;
         end
      end
      assign char_hit[k] = |pos_hit[k];
   end

   // A keyword matches when every character so far agreed and the length is exact.
   always_comb begin
      command = lcr_pkg::CMD_NONE;
      for (int k = lcr_pkg::KW_NUM - 1; k >= 0; k--) begin
         if (prefix_ok[k] && (eff_len == FILL_W'(lcr_pkg::KW_LEN[k]))) begin
            command = lcr_pkg::KW_CODE[k];
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lcr_line_tracker.sv -----
// Line state: fill count, effective length, zero-byte flag and keyword prefix flags.
`default_nettype none

module lcr_line_tracker #(
   parameter int LINE_CAPACITY = lcr_pkg::LINE_CAPACITY_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic [7:0]      rx_byte,
   output lcr_pkg::rsp_type     result
);

   localparam int FILL_W = $clog2(LINE_CAPACITY);
   localparam logic [FILL_W-1:0] STORE_DEPTH = FILL_W'(LINE_CAPACITY - 1);

   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [FILL_W-1:0]          eff_len_ff, eff_len_in;
   logic                       zero_seen_ff, zero_seen_in;
   logic [lcr_pkg::KW_NUM-1:0] prefix_ok_ff, prefix_ok_in;
   logic [lcr_pkg::KW_NUM-1:0] char_hit;
   logic [2:0]                 match_command;
   logic                       is_term;

   lcr_keyword_match #(
      .FILL_W(FILL_W)
   ) u_match (
      .rx_byte  (rx_byte),
      .position (fill_ff),
      .eff_len  (eff_len_ff),
      .prefix_ok(prefix_ok_ff),
      .char_hit (char_hit),
      .command  (match_command)
   );

   assign is_term = (rx_byte == lcr_pkg::BYTE_LF) || (rx_byte == lcr_pkg::BYTE_CR);

   // Next line state and the result for the byte being processed.
   always_comb begin
      fill_in = fill_ff;
      eff_len_in = eff_len_ff;
      zero_seen_in = zero_seen_ff;
      prefix_ok_in = prefix_ok_ff;
      result.command = lcr_pkg::CMD_NONE;
      result.line_complete = 1'b0;
      priority if (is_term) begin
         if (fill_ff != '0) begin
            result.command = match_command;
            result.line_complete = 1'b1;
            fill_in = '0;
            eff_len_in = '0;
            zero_seen_in = 1'b0;
            prefix_ok_in = '1;
         end
      end else if (fill_ff < STORE_DEPTH) begin
         fill_in = fill_ff + 1'b1;
         if (!zero_seen_ff) begin
            if (rx_byte == lcr_pkg::BYTE_NUL) begin
               zero_seen_in = 1'b1;
            end else begin
               eff_len_in = eff_len_ff + 1'b1;
               prefix_ok_in = prefix_ok_ff & char_hit;
            end
         end
      end else begin
         // Store overflow: the line is discarded and this byte dropped.
         fill_in = '0;
         eff_len_in = '0;
         zero_seen_in = 1'b0;
         prefix_ok_in = '1;
      end
   end

   // State registers update once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         eff_len_ff <= '0;
         zero_seen_ff <= 1'b0;
         prefix_ok_ff <= '1;
      end else if (advance) begin
         fill_ff <= fill_in;
         eff_len_ff <= eff_len_in;
         zero_seen_ff <= zero_seen_in;
         prefix_ok_ff <= prefix_ok_in;
      end
   end

   // The fill count never passes the store depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= STORE_DEPTH)
      else $error("fill count beyond store depth");

   // Before any zero byte, the compared length is the whole line.
   a_eff_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      !zero_seen_ff |-> (eff_len_ff == fill_ff))
      else $error("effective length diverged from fill count");

   // A completed line always leaves the tracker empty.
   a_clear_after_line: assert property (@(posedge clock) disable iff (reset)
      (advance && result.line_complete) |=> (fill_ff == '0 && !zero_seen_ff))
      else $error("line state not cleared after completion");

endmodule

`default_nettype wire
